FILE: hw/rtl/fpr_pkg.sv
// Shared constants, types and helper functions of the FIFO page replacement block.
package fpr_pkg;

	localparam int MAX_FRAMES    = 16;
	localparam int ADDRESS_BITS  = 32;
	localparam int PAGE_W        = 32;
	localparam int CFG_W         = 5;
	localparam int SLOT_W        = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int COUNT_W       = $clog2(MAX_FRAMES + 1);
	localparam int SHIFT_LIMIT   = 20;

	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [PAGE_W-1:0]  page_t;

	typedef enum logic {
		REG_FRAME_COUNT    = 1'b0,
		REG_PAGE_SIZE_LOG2 = 1'b1
	} reg_index_t;

	// Ring position base + offset, wrapped at MAX_FRAMES. Offset is at most MAX_FRAMES.
	function automatic slot_t slot_after(input slot_t base, input count_t offset);
		logic [COUNT_W:0] sum;
		sum = {{(COUNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, offset};
		if (sum >= (COUNT_W + 1)'(MAX_FRAMES)) begin
			sum = sum - (COUNT_W + 1)'(MAX_FRAMES);
		end
		return sum[SLOT_W-1:0];
	endfunction

	// Frame count as used by the replacement logic: zero acts as one, large values clip.
	function automatic count_t effective_frames(input logic [CFG_W-1:0] frame_count);
		count_t result;
		if (frame_count == '0) begin
			result = count_t'(1);
		end else if ({1'b0, frame_count} > (CFG_W + 1)'(MAX_FRAMES)) begin
			result = count_t'(MAX_FRAMES);
		end else begin
			result = count_t'(frame_count);
		end
		return result;
	endfunction

endpackage

FILE: hw/rtl/fifo_page_replacement_top.sv
// FIFO page replacement block: page lookup over a resident-page memory with FIFO eviction.
//
// Each item is an address; its page number is the address shifted right by page_size_log2
// (clipped at 20). The resident pages sit in one 16-entry synchronous memory that is walked
// from the oldest slot, one read and one compare per cycle, so a hit stops the walk at the
// matching entry while a miss reads every resident entry. On a miss the page is written at the ring tail;
// when the ring already holds at least the effective frame count of pages the oldest is retired as well.
// One item is worked on at a time;
// a new item is taken while the previous result still waits in the output register.
// Configuration writes are taken at any time but are meant for when the block is idle.
module fifo_page_replacement_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic                            cfg_index,
	input  logic [fpr_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [fpr_pkg::ADDRESS_BITS-1:0] address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fpr_pkg::PAGE_W-1:0]      page_number,
	output logic                            fault,
	output logic [31:0]                     fault_total,
	output logic signed [32:0]              distance,
	output logic                            distance_valid
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FINISH
	} state_t;

	state_t                        state_q;
	logic [fpr_pkg::CFG_W-1:0]     frame_count_q;
	logic [fpr_pkg::CFG_W-1:0]     page_size_log2_q;
	fpr_pkg::slot_t                oldest_q;
	fpr_pkg::count_t               count_q;
	fpr_pkg::count_t               idx_q;
	fpr_pkg::page_t                prev_page_q;
	logic                          seen_any_q;
	logic [31:0]                   fault_counter_q;
	fpr_pkg::page_t                page_q;
	logic signed [32:0]            dist_q;
	logic                          dist_valid_q;
	logic                          miss_q;
	logic                          rd_vld_s1;
	logic                          out_valid_q;
	fpr_pkg::page_t                out_page_q;
	logic                          out_fault_q;
	logic [31:0]                   out_total_q;
	logic signed [32:0]            out_dist_q;
	logic                          out_dist_valid_q;

	fpr_pkg::page_t                mem [fpr_pkg::MAX_FRAMES];
	fpr_pkg::page_t                rd_data_s1;
	fpr_pkg::slot_t                rd_addr;
	fpr_pkg::slot_t                wr_addr;
	logic                          wr_en;

	logic [4:0]                    shift;
	fpr_pkg::page_t                page_in;
	fpr_pkg::count_t               frames;
	logic                          in_accept;
	logic                          out_free;
	logic                          hit;
	logic                          walk_done;

	assign shift = (page_size_log2_q > 5'(fpr_pkg::SHIFT_LIMIT)) ?
		5'(fpr_pkg::SHIFT_LIMIT) : page_size_log2_q;
	assign page_in   = fpr_pkg::PAGE_W'(address >> shift);
	assign frames    = fpr_pkg::effective_frames(frame_count_q);
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// A read issued in one cycle is compared in the next.
	assign hit       = rd_vld_s1 && (rd_data_s1 == page_q);
	assign walk_done = (idx_q == count_q);
	assign rd_addr   = fpr_pkg::slot_after(oldest_q, idx_q);
	assign wr_addr   = fpr_pkg::slot_after(oldest_q, count_q);
	assign wr_en     = (state_q == ST_FINISH) && out_free && miss_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= page_q;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			frame_count_q    <= fpr_pkg::CFG_W'(16);
			page_size_log2_q <= fpr_pkg::CFG_W'(12);
			oldest_q         <= '0;
			count_q          <= '0;
			idx_q            <= '0;
			prev_page_q      <= '0;
			seen_any_q       <= 1'b0;
			fault_counter_q  <= '0;
			rd_vld_s1        <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (fpr_pkg::reg_index_t'(cfg_index))
					fpr_pkg::REG_FRAME_COUNT:    frame_count_q    <= cfg_data;
					fpr_pkg::REG_PAGE_SIZE_LOG2: page_size_log2_q <= cfg_data;
					default: ;
				endcase
			end

			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_accept) begin
						page_q       <= page_in;
						dist_q       <= seen_any_q ?
							($signed({1'b0, page_in}) - $signed({1'b0, prev_page_q})) : '0;
						dist_valid_q <= seen_any_q;
						prev_page_q  <= page_in;
						seen_any_q   <= 1'b1;
						idx_q        <= '0;
						state_q      <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (!walk_done) begin
						idx_q     <= idx_q + 1'b1;
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
					end
					if (hit) begin
						miss_q  <= 1'b0;
						state_q <= ST_FINISH;
					end else if (walk_done) begin
						miss_q  <= 1'b1;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					rd_vld_s1 <= 1'b0;
					if (out_free) begin
						out_page_q       <= page_q;
						out_fault_q      <= miss_q;
						out_dist_q       <= dist_q;
						out_dist_valid_q <= dist_valid_q;
						if (miss_q && fault_counter_q != '1) begin
							fault_counter_q <= fault_counter_q + 1'b1;
							out_total_q     <= fault_counter_q + 1'b1;
						end else begin
							out_total_q     <= fault_counter_q;
						end
						if (miss_q) begin
							// A full ring retires its oldest page; the tail is written in the same cycle.
							if (count_q < frames) begin
								count_q <= count_q + 1'b1;
							end else begin
								oldest_q <= fpr_pkg::slot_after(oldest_q, fpr_pkg::count_t'(1));
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign page_number    = out_page_q;
	assign fault          = out_fault_q;
	assign fault_total    = out_total_q;
	assign distance       = out_dist_q;
	assign distance_valid = out_dist_valid_q;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench of the FIFO page replacement block with directed and random traffic.
`timescale 1ns / 100ps

module tb_top;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [31:0] page_number;
		logic        fault;
		logic [31:0] fault_total;
		logic [32:0] distance;
		logic        distance_valid;
	} access_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic cfg_index = fpr_pkg::REG_FRAME_COUNT;
	logic [fpr_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [fpr_pkg::ADDRESS_BITS-1:0] address = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [fpr_pkg::PAGE_W-1:0] page_number;
	logic fault;
	logic [31:0] fault_total;
	logic signed [32:0] distance;
	logic distance_valid;

	// Mirror of the block's page table and registers.
	logic [fpr_pkg::CFG_W-1:0] frame_cfg = 5'd16;
	logic [fpr_pkg::CFG_W-1:0] shift_cfg = 5'd12;
	fpr_pkg::page_t ring_pages [fpr_pkg::MAX_FRAMES];
	int unsigned ring_head = 0;
	int unsigned ring_fill = 0;
	fpr_pkg::page_t last_page = '0;
	logic seen_access = 1'b0;
	logic [31:0] fault_tally = '0;

	access_result_t pending_results [$];
	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;
	int unsigned quiet_cycles = 0;

	logic [31:0] stall_cycle = '0;
	int unsigned stall_mode = 0;
	int unsigned hold_ticket = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;

	fifo_page_replacement_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.address(address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.page_number(page_number),
		.fault(fault),
		.fault_total(fault_total),
		.distance(distance),
		.distance_valid(distance_valid)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic access_result_t predict_access(input logic [31:0] addr);
		access_result_t r;
		int unsigned shift;
		int unsigned frames;
		int unsigned i;
		int unsigned tail;
		logic hit;
		shift = (shift_cfg > fpr_pkg::SHIFT_LIMIT) ? fpr_pkg::SHIFT_LIMIT : shift_cfg;
		if (frame_cfg == 0) begin
			frames = 1;
		end else if (frame_cfg > fpr_pkg::MAX_FRAMES) begin
			frames = fpr_pkg::MAX_FRAMES;
		end else begin
			frames = 32'(frame_cfg);
		end
		r.page_number = addr >> shift;
		r.distance_valid = seen_access;
		r.distance = seen_access ? ({1'b0, r.page_number} - {1'b0, last_page}) : '0;
		last_page = r.page_number;
		seen_access = 1'b1;
		hit = 1'b0;
		for (i = 0; i < ring_fill; i++) begin
			if (ring_pages[(ring_head + i) % fpr_pkg::MAX_FRAMES] == r.page_number) begin
				hit = 1'b1;
			end
		end
		r.fault = !hit;
		if (!hit) begin
			if (fault_tally != 32'hFFFF_FFFF) begin
				fault_tally++;
			end
			tail = (ring_head + ring_fill) % fpr_pkg::MAX_FRAMES;
			if (ring_fill < frames) begin
				ring_fill++;
			end else begin
				// The ring stays at its current fill even when the frame count was lowered.
				ring_head = (ring_head + 1) % fpr_pkg::MAX_FRAMES;
			end
			ring_pages[tail] = r.page_number;
		end
		r.fault_total = fault_tally;
		return r;
	endfunction

	// Sends one address item; bursts of random length are separated by idle gaps.
	task automatic send_address(input logic [31:0] addr);
		int unsigned gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		address <= addr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_access(addr));
		burst_left--;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_paging(input logic [fpr_pkg::CFG_W-1:0] frames,
			input logic [fpr_pkg::CFG_W-1:0] log2);
		cfg_write <= 1'b1;
		cfg_index <= fpr_pkg::REG_FRAME_COUNT;
		cfg_data <= frames;
		@(posedge clk);
		cfg_index <= fpr_pkg::REG_PAGE_SIZE_LOG2;
		cfg_data <= log2;
		@(posedge clk);
		cfg_write <= 1'b0;
		frame_cfg = frames;
		shift_cfg = log2;
	endtask

	task automatic test_reset_defaults();
		// The first item after reset carries no distance.
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0FFF);
		send_address(32'hFFFF_F000);
		drain_results();
	endtask

	task automatic test_fifo_eviction();
		set_paging(5'd3, 5'd0);
		send_address(32'd10);
		send_address(32'd11);
		send_address(32'd12);
		send_address(32'd13);
		send_address(32'd10);
		send_address(32'd12);
		drain_results();
	endtask

	task automatic test_frame_shrink();
		int unsigned pg;
		set_paging(5'd6, 5'd4);
		for (pg = 1; pg <= 5; pg++) begin
			send_address(pg << 4);
		end
		drain_results();
		// Lowering the frame count keeps the resident pages; later faults replace the oldest.
		set_paging(5'd2, 5'd4);
		send_address(32'h0000_0090);
		send_address(32'h0000_002F);
		send_address(32'h0000_0015);
		drain_results();
	endtask

	task automatic test_register_clipping();
		set_paging(5'd0, 5'd31);
		send_address(32'hFFFF_FFFF);
		send_address(32'h0000_0000);
		drain_results();
		set_paging(5'd31, 5'd21);
		send_address(32'h8000_0000);
		send_address(32'h7FFF_FFFF);
		drain_results();
	endtask

	task automatic run_random_phase(input logic [fpr_pkg::CFG_W-1:0] frames,
			input logic [fpr_pkg::CFG_W-1:0] log2, input int unsigned items,
			input bit long_hold);
		fpr_pkg::page_t pool [32];
		int unsigned pool_len;
		int unsigned shift;
		int unsigned eff;
		int unsigned pick;
		int unsigned i;
		logic [31:0] pg;
		logic [31:0] mask;
		logic [31:0] addr;
		set_paging(frames, log2);
		shift = (log2 > fpr_pkg::SHIFT_LIMIT) ? fpr_pkg::SHIFT_LIMIT : 32'(log2);
		eff = (frames == 0) ? 1 :
			((frames > fpr_pkg::MAX_FRAMES) ? fpr_pkg::MAX_FRAMES : 32'(frames));
		// A working set as large as the frames or a little larger gives a mix of hits and evictions.
		pool_len = eff + $urandom_range(0, 6);
		for (i = 0; i < pool_len; i++) begin
			pool[i] = $urandom >> shift;
		end
		mask = (32'd1 << shift) - 1;
		if (long_hold) begin
			hold_ticket <= hold_ticket + 1;
		end
		pg = pool[0];
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				pg = pool[$urandom_range(0, pool_len - 1)];
			end else if (pick < 88) begin
				pg = pg + $urandom_range(0, 4) - 2;
			end else begin
				pg = $urandom >> shift;
			end
			addr = (pg << shift) | ($urandom & mask);
			if (pick >= 95) begin
				addr = $urandom;
			end
			send_address(addr);
		end
		drain_results();
	endtask

	task automatic test_random_traffic();
		int unsigned phase;
		logic [fpr_pkg::CFG_W-1:0] frames;
		logic [fpr_pkg::CFG_W-1:0] log2;
		for (phase = 0; phase < 10; phase++) begin
			frames = ($urandom_range(0, 9) == 0) ? fpr_pkg::CFG_W'($urandom_range(0, 31))
				: fpr_pkg::CFG_W'($urandom_range(1, 16));
			log2 = ($urandom_range(0, 9) == 0) ? fpr_pkg::CFG_W'($urandom_range(0, 31))
				: fpr_pkg::CFG_W'($urandom_range(0, 20));
			case (phase)
				0: begin frames = 5'd1; log2 = 5'd20; end
				1: begin frames = 5'd16; log2 = 5'd0; end
				2: begin frames = 5'd0; log2 = 5'd31; end
				3: begin frames = 5'd31; log2 = 5'd21; end
				default: ;
			endcase
			run_random_phase(frames, log2, 183, phase == 4);
		end
	endtask

	// Receiver stall pattern: a stall mode drawn at random, with an occasional long hold.
	always @(posedge clk) begin
		stall_cycle <= stall_cycle + 1;
		if (stall_cycle[5:0] == 6'd0) begin
			stall_mode <= $urandom_range(0, 2);
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_ticket != hold_taken) begin
			hold_taken <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		access_result_t want;
		access_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {page_number, fault, fault_total, distance, distance_valid};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("Unexpected result: page %h fault %b total %0d distance %0d valid %b",
						page_number, fault, fault_total, distance, distance_valid);
				end
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("Mismatch: expected page %h fault %b total %0d distance %0d valid %b",
							want.page_number, want.fault, want.fault_total,
							$signed(want.distance), want.distance_valid);
						$display("          actual   page %h fault %b total %0d distance %0d valid %b",
							page_number, fault, fault_total, distance, distance_valid);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_fifo_eviction();
		test_frame_shrink();
		test_register_clipping();
		test_random_traffic();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/fpr_pkg.sv
hw/rtl/fifo_page_replacement_top.sv
tb/sv/tb_top.sv
